/* sv/gbtp_pkg.sv */
package gbtp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W    = 13;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int PROW_W   = $clog2(MAX_HEIGHT + 2);
    localparam int T_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
    localparam int DLY_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int DLY_AW   = $clog2(DLY_DEPTH);
    localparam int CMP_W    = DIM_W + 1;

    localparam int DISP_W   = 16;
    localparam int SIXT_W   = 18;
    localparam int SUBPIX_SHIFT = 4;

    localparam logic [DISP_W-1:0] NO_DATA     = 16'hFFFF;
    localparam logic [SIXT_W-1:0] DISP_OFFSET = SIXT_W'(16384);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DOUBLE_RING  = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        logic [COL_W-1:0]  left_column;
        logic [ROW_W-1:0]  left_row;
        logic [SIXT_W-1:0] right_column_sixteenths;
        logic [SIXT_W-1:0] right_row_sixteenths;
        logic              kept;
        logic              frame_last;
    } out_rec_t;

    typedef struct packed
    {
        logic              in_frame;
        logic              pix_valid;
        logic [COL_W-1:0]  in_col;
        logic              p_on;
        logic              fp_wr;
        logic [COL_W-1:0]  p_col;
        logic [PROW_W-1:0] p_row;
        logic              k_on;
        logic [COL_W-1:0]  k_col;
        logic [ROW_W-1:0]  k_row;
        logic              last;
        logic              fwd_v;
        logic              fwd_f;
    } s1_t;

    typedef struct packed
    {
        logic              p_on;
        logic              k_on;
        logic              fp_p;
        logic [2:0]        vec_f;
        logic [COL_W-1:0]  k_col;
        logic [ROW_W-1:0]  k_row;
        logic              last;
    } s2_t;

endpackage

/* sv/gbtp_out_fifo.sv */
module gbtp_out_fifo
    import gbtp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  out_rec_t           push_data,
    input  logic               pop,
    output logic               valid,
    output out_rec_t           head,
    output logic [FIFO_CW-1:0] count
);

    out_rec_t               store [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_CW-1:0]     count_reg;
    logic [FIFO_CW-1:0]     count_next;

    assign valid = (count_reg != '0);
    assign head  = store[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/gap_border_tie_point_extract.sv */
// Channel  Direction  Handshake            Beat
// in       input      in_valid/in_ready    opcode, disparity_x, disparity_y
// out      output     out_valid/out_ready  left_column, left_row, right_*_sixteenths,
//                                          kept, frame_last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input beat per cycle while in_ready is high; a decision passes the s1 stage, where the
// line memories are read, and the s2 window stage before it enters the output queue.
// Line memories are not cleared at reset; every entry read is written earlier in the frame.
// A four-entry result queue absorbs output stalls; input is held off when queued and in-flight decisions fill it.
// The cycle after a write to one of the three configuration registers takes no input beat.
module gap_border_tie_point_extract
    import gbtp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [DISP_W-1:0]        disparity_x,
    input  logic [DISP_W-1:0]        disparity_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COL_W-1:0]         left_column,
    output logic [ROW_W-1:0]         left_row,
    output logic signed [SIXT_W-1:0] right_column_sixteenths,
    output logic signed [SIXT_W-1:0] right_row_sixteenths,
    output logic                     kept,
    output logic                     frame_last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [DIM_W-1:0]         cfg_data
);

    logic [DIM_W-1:0]   width_cfg_reg;
    logic [DIM_W-1:0]   height_cfg_reg;
    logic               dbl_reg;
    logic               settle_reg;
    logic               cfg_hit;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [2*DIM_W-1:0] area;
    logic [DLY_AW-1:0]  lat_next;

    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   h_reg;
    logic [COL_W-1:0]   w_m1_reg;
    logic [ROW_W-1:0]   h_m1_reg;
    logic [T_W-1:0]     total_reg;
    logic [T_W-1:0]     p_start_reg;
    logic [DLY_AW-1:0]  lat_reg;
    logic [DLY_AW-1:0]  lat_m1_reg;

    logic [T_W-1:0]     t_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [COL_W-1:0]   p_col_reg;
    logic [PROW_W-1:0]  p_row_reg;
    logic [COL_W-1:0]   k_col_reg;
    logic [ROW_W-1:0]   k_row_reg;
    logic [DLY_AW-1:0]  dm_ptr_reg;

    logic               in_frame;
    logic               step;
    logic               p_on;
    logic               k_on;
    logic               fp_wr;
    logic               last;
    logic               pix_valid;

    logic [1:0]         vm_mem [MAX_WIDTH];
    logic [1:0]         fm_mem [MAX_WIDTH];
    logic [2*DISP_W-1:0] dm_mem [DLY_DEPTH];
    logic [1:0]         vm_q;
    logic [1:0]         fm_q;
    logic [2*DISP_W-1:0] dm_q;
    logic [1:0]         vfwd_reg;
    logic [1:0]         ffwd_reg;

    logic               s1_valid_reg;
    s1_t                s1_reg;
    s1_t                s1_next;
    logic               s2_valid_reg;
    s2_t                s2_reg;
    s2_t                s2_next;
    logic [2*DISP_W-1:0] s2_disp_reg;

    logic [2:0]         vw0_reg;
    logic [2:0]         vw1_reg;
    logic [2:0]         fw0_reg;
    logic [2:0]         fw1_reg;

    logic [1:0]         vq;
    logic [1:0]         fq;
    logic [2:0]         vec_v;
    logic [1:0]         vm_wdata;
    logic [1:0]         fm_wdata;
    logic               int_p;
    logic               all8;
    logic               fp_p;

    logic               int_k;
    logic               any8;
    logic               val_k;
    logic               kept_c;
    logic [DISP_W-1:0]  kdx;
    logic [DISP_W-1:0]  kdy;
    out_rec_t           rec;
    logic               push;
    out_rec_t           head;
    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW:0]   reserved;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                       cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_DOUBLE_RING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= DIM_W'(MAX_WIDTH);
            height_cfg_reg <= DIM_W'(MAX_HEIGHT);
            dbl_reg        <= 1'b0;
            settle_reg     <= 1'b0;
        end
        else
        begin
            settle_reg <= cfg_hit;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                    REG_DOUBLE_RING:  dbl_reg        <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    // A dimension of zero acts as one; anything above the maximum saturates.
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (width_cfg_reg > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_cfg_reg;
        end
        if (height_cfg_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (height_cfg_reg > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_cfg_reg;
        end
        area     = w_eff * h_eff;
        lat_next = dbl_reg ? (DLY_AW'(w_eff) << 1) + DLY_AW'(2) : DLY_AW'(w_eff) + DLY_AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= DIM_W'(MAX_WIDTH);
            h_reg       <= DIM_W'(MAX_HEIGHT);
            w_m1_reg    <= COL_W'(MAX_WIDTH - 1);
            h_m1_reg    <= ROW_W'(MAX_HEIGHT - 1);
            total_reg   <= T_W'(MAX_WIDTH * MAX_HEIGHT);
            p_start_reg <= T_W'(MAX_WIDTH + 1);
            lat_reg     <= DLY_AW'(MAX_WIDTH + 1);
            lat_m1_reg  <= DLY_AW'(MAX_WIDTH);
        end
        else
        begin
            w_reg       <= w_eff;
            h_reg       <= h_eff;
            w_m1_reg    <= COL_W'(w_eff - DIM_W'(1));
            h_m1_reg    <= ROW_W'(h_eff - DIM_W'(1));
            total_reg   <= area[T_W-1:0];
            p_start_reg <= T_W'(w_eff) + T_W'(1);
            lat_reg     <= lat_next;
            lat_m1_reg  <= lat_next - DLY_AW'(1);
        end
    end

    assign in_frame  = t_reg < total_reg;
    assign p_on      = t_reg >= p_start_reg;
    assign k_on      = t_reg >= T_W'(lat_reg);
    assign fp_wr     = p_on && (p_row_reg < PROW_W'(h_reg));
    assign last      = k_on && (k_col_reg == w_m1_reg) && (k_row_reg == h_m1_reg);
    assign pix_valid = (disparity_x != NO_DATA) && (disparity_y != NO_DATA);
    assign step      = in_valid && in_ready && !(opcode == OP_DRAIN && in_frame);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg      <= '0;
            in_col_reg <= '0;
            p_col_reg  <= '0;
            p_row_reg  <= '0;
            k_col_reg  <= '0;
            k_row_reg  <= '0;
            dm_ptr_reg <= '0;
        end
        else if (cfg_hit || (step && last))
        begin
            t_reg      <= '0;
            in_col_reg <= '0;
            p_col_reg  <= '0;
            p_row_reg  <= '0;
            k_col_reg  <= '0;
            k_row_reg  <= '0;
            dm_ptr_reg <= '0;
        end
        else if (step)
        begin
            t_reg      <= t_reg + T_W'(1);
            in_col_reg <= (in_col_reg == w_m1_reg) ? '0 : in_col_reg + COL_W'(1);
            dm_ptr_reg <= (dm_ptr_reg == lat_m1_reg) ? '0 : dm_ptr_reg + DLY_AW'(1);
            if (p_on)
            begin
                if (p_col_reg == w_m1_reg)
                begin
                    p_col_reg <= '0;
                    p_row_reg <= p_row_reg + PROW_W'(1);
                end
                else
                begin
                    p_col_reg <= p_col_reg + COL_W'(1);
                end
            end
            if (k_on)
            begin
                if (k_col_reg == w_m1_reg)
                begin
                    k_col_reg <= '0;
                    k_row_reg <= k_row_reg + ROW_W'(1);
                end
                else
                begin
                    k_col_reg <= k_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        s1_next.in_frame  = in_frame;
        s1_next.pix_valid = pix_valid;
        s1_next.in_col    = in_col_reg;
        s1_next.p_on      = p_on;
        s1_next.fp_wr     = fp_wr;
        s1_next.p_col     = p_col_reg;
        s1_next.p_row     = p_row_reg;
        s1_next.k_on      = k_on;
        s1_next.k_col     = k_col_reg;
        s1_next.k_row     = k_row_reg;
        s1_next.last      = last;
        s1_next.fwd_v     = s1_valid_reg && s1_reg.in_frame && (s1_reg.in_col == in_col_reg);
        s1_next.fwd_f     = s1_valid_reg && s1_reg.fp_wr && (s1_reg.p_col == p_col_reg);
    end

    // Line memories: validity and first-pass result of the two rows above, per column.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            vm_q <= vm_mem[in_col_reg];
            fm_q <= fm_mem[p_col_reg];
        end
        if (s1_valid_reg && s1_reg.in_frame)
        begin
            vm_mem[s1_reg.in_col] <= vm_wdata;
            vfwd_reg              <= vm_wdata;
        end
        if (s1_valid_reg && s1_reg.fp_wr)
        begin
            fm_mem[s1_reg.p_col] <= fm_wdata;
            ffwd_reg             <= fm_wdata;
        end
    end

    // Disparity delay line of the current latency; read returns the old entry.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dm_q <= dm_mem[dm_ptr_reg];
            if (in_frame)
            begin
                dm_mem[dm_ptr_reg] <= {disparity_y, disparity_x};
            end
        end
    end

    always_comb
    begin
        vq       = s1_reg.fwd_v ? vfwd_reg : vm_q;
        fq       = s1_reg.fwd_f ? ffwd_reg : fm_q;
        vec_v    = {vq[0], vq[1], s1_reg.pix_valid};
        vm_wdata = {s1_reg.pix_valid, vq[1]};
        all8     = (&vw0_reg) & (&vec_v) & vw1_reg[2] & vw1_reg[0];
        int_p    = (s1_reg.p_row != '0) && (s1_reg.p_col != '0) &&
                   (CMP_W'(s1_reg.p_row) + CMP_W'(2) <= CMP_W'(h_reg)) &&
                   (CMP_W'(s1_reg.p_col) + CMP_W'(2) <= CMP_W'(w_reg));
        fp_p     = vw1_reg[1] && !(int_p && all8);
        fm_wdata = {fp_p, fq[1]};

        s2_next.p_on  = s1_reg.p_on;
        s2_next.k_on  = s1_reg.k_on;
        s2_next.fp_p  = fp_p;
        s2_next.vec_f = {fq[0], fq[1], fp_p};
        s2_next.k_col = s1_reg.k_col;
        s2_next.k_row = s1_reg.k_row;
        s2_next.last  = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= step;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg)
        begin
            s2_reg      <= s2_next;
            s2_disp_reg <= dm_q;
            vw0_reg     <= vw1_reg;
            vw1_reg     <= vec_v;
        end
        if (s2_valid_reg && s2_reg.p_on)
        begin
            fw0_reg <= fw1_reg;
            fw1_reg <= s2_reg.vec_f;
        end
    end

    always_comb
    begin
        kdx    = s2_disp_reg[DISP_W-1:0];
        kdy    = s2_disp_reg[2*DISP_W-1:DISP_W];
        val_k  = (kdx != NO_DATA) && (kdy != NO_DATA);
        int_k  = (s2_reg.k_row != '0) && (s2_reg.k_col != '0) &&
                 (CMP_W'(s2_reg.k_row) + CMP_W'(2) <= CMP_W'(h_reg)) &&
                 (CMP_W'(s2_reg.k_col) + CMP_W'(2) <= CMP_W'(w_reg));
        any8   = (|fw0_reg) | (|s2_reg.vec_f) | fw1_reg[2] | fw1_reg[0];
        kept_c = dbl_reg ? (fw1_reg[1] || (val_k && int_k && any8)) : s2_reg.fp_p;

        rec.left_column = s2_reg.k_col;
        rec.left_row    = s2_reg.k_row;
        rec.kept        = kept_c;
        rec.frame_last  = s2_reg.last;
        if (kept_c)
        begin
            rec.right_column_sixteenths = (SIXT_W'(s2_reg.k_col) << SUBPIX_SHIFT)
                                          + SIXT_W'(kdx) - DISP_OFFSET;
            rec.right_row_sixteenths    = (SIXT_W'(s2_reg.k_row) << SUBPIX_SHIFT)
                                          + SIXT_W'(kdy) - DISP_OFFSET;
        end
        else
        begin
            rec.right_column_sixteenths = '0;
            rec.right_row_sixteenths    = '0;
        end
    end

    assign push = s2_valid_reg && s2_reg.k_on;

    gbtp_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (rec),
        .pop       (out_valid && out_ready),
        .valid     (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    // Queue space is reserved for every decision still in the pipeline.
    assign reserved = (FIFO_CW + 1)'(fifo_count)
                      + (FIFO_CW + 1)'(s1_valid_reg && s1_reg.k_on)
                      + (FIFO_CW + 1)'(s2_valid_reg && s2_reg.k_on);
    assign in_ready = !settle_reg && (reserved < (FIFO_CW + 1)'(FIFO_DEPTH));

    assign left_column             = head.left_column;
    assign left_row                = head.left_row;
    assign right_column_sixteenths = head.right_column_sixteenths;
    assign right_row_sixteenths    = head.right_row_sixteenths;
    assign kept                    = head.kept;
    assign frame_last              = head.frame_last;

endmodule

/* tb/tb_top.sv */
module tb_top;
    import gbtp_pkg::*;

    localparam int unsigned ITEM_GOAL   = 1600;
    localparam int unsigned LONG_STALL  = 400;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned MAX_PRINTS  = 100;
    localparam int unsigned VAL_SLOTS   = 3 * MAX_WIDTH + 2;
    localparam int unsigned THIN_SLOTS  = 2 * MAX_WIDTH + 4;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed
    {
        opcode_t           op;
        logic [DISP_W-1:0] dx;
        logic [DISP_W-1:0] dy;
    } disparity_beat_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     opcode = OP_PIXEL;
    logic [DISP_W-1:0]        disparity_x = '0;
    logic [DISP_W-1:0]        disparity_y = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [COL_W-1:0]         left_column;
    logic [ROW_W-1:0]         left_row;
    logic signed [SIXT_W-1:0] right_column_sixteenths;
    logic signed [SIXT_W-1:0] right_row_sixteenths;
    logic                     kept;
    logic                     frame_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = '0;
    logic [DIM_W-1:0]         cfg_data = '0;

    // Handshake flags captured at the rising edge for the falling-edge processes.
    logic in_beat = 1'b0;
    logic cfg_beat = 1'b0;

    disparity_beat_t beats_to_send[$];
    out_rec_t        tie_points_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_asks = 0;
    int unsigned stall_done = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned beats_in = 0;
    int unsigned decisions = 0;
    int unsigned kept_total = 0;
    int unsigned frames_run = 0;
    int unsigned shapes_used = 0;
    int unsigned random_beats = 0;

    logic [DIM_W-1:0] width_reg = 13'd4096;
    logic [DIM_W-1:0] height_reg = 13'd4096;
    logic             ring_reg = 1'b0;
    int unsigned      next_col = 0;
    int unsigned      next_row = 0;
    bit               valid_hist[VAL_SLOTS];
    bit               thinned_hist[THIN_SLOTS];
    logic [31:0]      disp_hist[DLY_DEPTH];

    gap_border_tie_point_extract dut
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .opcode                  (opcode),
        .disparity_x             (disparity_x),
        .disparity_y             (disparity_y),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .left_column             (left_column),
        .left_row                (left_row),
        .right_column_sixteenths (right_column_sixteenths),
        .right_row_sixteenths    (right_row_sixteenths),
        .kept                    (kept),
        .frame_last              (frame_last),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned frame_lag();
        int unsigned cols;
        cols = eff_dim(width_reg, MAX_WIDTH);
        return ring_reg ? 2 * cols + 2 : cols + 1;
    endfunction

    function automatic bit is_inner(input int unsigned p, w, h);
        int unsigned r, c;
        r = p / w;
        c = p % w;
        return r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w;
    endfunction

    function automatic bit had_data(input int unsigned p);
        return valid_hist[p % VAL_SLOTS];
    endfunction

    function automatic bit thinned_at(input int unsigned p);
        return thinned_hist[p % THIN_SLOTS];
    endfunction

    function automatic bit survives_first(input int unsigned p, w, h);
        if (!had_data(p))
            return 0;
        if (!is_inner(p, w, h))
            return 1;
        return !(had_data(p - w - 1) && had_data(p - w) && had_data(p - w + 1) &&
                 had_data(p - 1) && had_data(p + 1) &&
                 had_data(p + w - 1) && had_data(p + w) && had_data(p + w + 1));
    endfunction

    function automatic bit survives_second(input int unsigned k, w, h);
        if (thinned_at(k))
            return 1;
        if (!had_data(k) || !is_inner(k, w, h))
            return 0;
        return thinned_at(k - w - 1) || thinned_at(k - w) || thinned_at(k - w + 1) ||
               thinned_at(k - 1) || thinned_at(k + 1) ||
               thinned_at(k + w - 1) || thinned_at(k + w) || thinned_at(k + w + 1);
    endfunction

    // Returns 1 when the beat releases a decision, which is then placed in rec.
    function automatic bit decide_pixel(input opcode_t op, input logic [DISP_W-1:0] dx,
                                        input logic [DISP_W-1:0] dy, output out_rec_t rec);
        int unsigned w, h, total, lag, t, p, k, col, row;
        logic [31:0] held;
        bit keep, last, made;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        lag = ring_reg ? 2 * w + 2 : w + 1;
        t = next_row * w + next_col;
        rec = '0;
        made = 0;
        last = 0;
        if (t < total)
        begin
            if (op == OP_DRAIN)
                return 0;
            valid_hist[t % VAL_SLOTS] = (dx != NO_DATA) && (dy != NO_DATA);
        end
        if (t >= w + 1)
        begin
            p = t - w - 1;
            if (p < total)
                thinned_hist[p % THIN_SLOTS] = survives_first(p, w, h);
        end
        if (t >= lag)
        begin
            k = t - lag;
            keep = ring_reg ? survives_second(k, w, h) : thinned_at(k);
            held = disp_hist[k % DLY_DEPTH];
            row = k / w;
            col = k % w;
            last = (k == total - 1);
            rec.left_column = COL_W'(col);
            rec.left_row = ROW_W'(row);
            if (keep)
            begin
                rec.right_column_sixteenths =
                    SIXT_W'((col << SUBPIX_SHIFT) + held[15:0]) - DISP_OFFSET;
                rec.right_row_sixteenths =
                    SIXT_W'((row << SUBPIX_SHIFT) + held[31:16]) - DISP_OFFSET;
            end
            rec.kept = keep;
            rec.frame_last = last;
            made = 1;
        end
        if (t < total)
            disp_hist[t % DLY_DEPTH] = {dy, dx};
        if (last)
        begin
            next_col = 0;
            next_row = 0;
        end
        else
        begin
            next_col++;
            if (next_col >= w)
            begin
                next_col = 0;
                next_row++;
            end
        end
        return made;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (fail_count < MAX_PRINTS)
            $display("Mismatch on %s at decision %0d: got %0d, expected %0d",
                     field, decisions, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_rec_t want;
        if (!rst_n)
        begin
            in_beat <= 1'b0;
            cfg_beat <= 1'b0;
        end
        else
        begin
            in_beat <= in_valid && in_ready;
            cfg_beat <= cfg_valid && cfg_ready;
            if (out_valid && out_ready)
            begin
                decisions++;
                if (tie_points_due.size() == 0)
                    report_mismatch("unexpected beat, left_column", left_column, -1);
                else
                begin
                    want = tie_points_due.pop_front();
                    if (left_column !== want.left_column)
                        report_mismatch("left_column", left_column, want.left_column);
                    if (left_row !== want.left_row)
                        report_mismatch("left_row", left_row, want.left_row);
                    if (right_column_sixteenths !== want.right_column_sixteenths)
                        report_mismatch("right_column_sixteenths", right_column_sixteenths,
                                        $signed(want.right_column_sixteenths));
                    if (right_row_sixteenths !== want.right_row_sixteenths)
                        report_mismatch("right_row_sixteenths", right_row_sixteenths,
                                        $signed(want.right_row_sixteenths));
                    if (kept !== want.kept)
                        report_mismatch("kept", kept, want.kept);
                    if (frame_last !== want.frame_last)
                        report_mismatch("frame_last", frame_last, want.frame_last);
                end
            end
            if (cfg_valid && cfg_ready && cfg_index != REG_UNUSED)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
                else
                    ring_reg = cfg_data[0];
                next_col = 0;
                next_row = 0;
            end
            if (in_valid && in_ready)
            begin
                beats_in++;
                if (decide_pixel(opcode_t'(opcode), disparity_x, disparity_y, want))
                begin
                    tie_points_due.push_back(want);
                    if (want.kept)
                        kept_total++;
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        disparity_beat_t item;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_beat)
        begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = beats_to_send.pop_front();
                in_valid <= 1'b1;
                opcode <= item.op;
                disparity_x <= item.dx;
                disparity_y <= item.dy;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (stall_done != stall_asks)
        begin
            stall_done <= stall_asks;
            stall_left <= LONG_STALL;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d decisions outstanding",
                     cycle_count, tie_points_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (beats_to_send.size() != 0 || in_valid);
        do
            @(negedge clk);
        while (tie_points_due.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        wait_idle();
        repeat (8) @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_beat);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic ring);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_DOUBLE_RING, {{(DIM_W-1){1'b0}}, ring});
        shapes_used++;
    endtask

    task automatic set_idle(input int unsigned mode);
        @(posedge clk);
        send_idle_pct = (mode == 1) ? 48 : (mode == 3) ? 34 : 0;
        recv_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 34 : 0;
    endtask

    // Drain beats slipped in before the frame is complete are ignored by the block.
    task automatic queue_pixels(input int unsigned count, input int unsigned hole_pct);
        logic [DISP_W-1:0] dx, dy;
        @(posedge clk);
        repeat (count)
        begin
            if ($urandom_range(99) < 3)
                beats_to_send.push_back('{OP_DRAIN, DISP_W'($urandom), DISP_W'($urandom)});
            dx = DISP_W'($urandom_range(0, 65534));
            dy = DISP_W'($urandom_range(0, 65534));
            if ($urandom_range(99) < hole_pct)
            begin
                case ($urandom_range(2))
                    0: dx = NO_DATA;
                    1: dy = NO_DATA;
                    default:
                    begin
                        dx = NO_DATA;
                        dy = NO_DATA;
                    end
                endcase
            end
            beats_to_send.push_back('{OP_PIXEL, dx, dy});
        end
    endtask

    // Pixel beats after the frame is complete act as drain steps.
    task automatic queue_drains(input int unsigned count);
        opcode_t op;
        @(posedge clk);
        repeat (count)
        begin
            op = ($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN;
            beats_to_send.push_back('{op, DISP_W'($urandom), DISP_W'($urandom)});
        end
    endtask

    initial
    begin
        int unsigned hole_choices[6];
        int unsigned pixels, split, hole, lag;
        bit must_write;
        hole_choices = '{0, 3, 15, 40, 80, 100};
        must_write = 1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A few pixels under the reset shape, cut off by the first register write.
        queue_pixels(3, 50);

        set_shape(13'd3, 13'd3, 1'b0);
        @(posedge clk);
        beats_to_send.push_back('{OP_PIXEL, 16'd0, 16'd0});
        beats_to_send.push_back('{OP_PIXEL, 16'd65534, 16'd65534});
        beats_to_send.push_back('{OP_PIXEL, NO_DATA, 16'd100});
        beats_to_send.push_back('{OP_PIXEL, 16'd16384, NO_DATA});
        beats_to_send.push_back('{OP_DRAIN, 16'hA5A5, 16'h5A5A});
        beats_to_send.push_back('{OP_PIXEL, 16'd16384, 16'd16384});
        beats_to_send.push_back('{OP_PIXEL, NO_DATA, NO_DATA});
        beats_to_send.push_back('{OP_PIXEL, 16'hFFFE, 16'h0001});
        beats_to_send.push_back('{OP_PIXEL, 16'h8000, 16'h7FFF});
        beats_to_send.push_back('{OP_PIXEL, 16'h5555, 16'hAAAA});
        beats_to_send.push_back('{OP_DRAIN, 16'h0, 16'h0});
        beats_to_send.push_back('{OP_PIXEL, 16'h1234, 16'h4321});
        beats_to_send.push_back('{OP_DRAIN, 16'hFFFF, 16'hFFFF});
        beats_to_send.push_back('{OP_DRAIN, 16'h0, 16'h0});
        frames_run++;

        set_shape(13'd3, 13'd3, 1'b1);
        queue_pixels(9, 0);
        queue_drains(frame_lag());
        frames_run++;

        set_shape(13'd0, 13'd5, 1'b0);
        queue_pixels(5, 30);
        queue_drains(frame_lag());
        frames_run++;

        // A write to an index past the register list must not restart the frame.
        set_shape(13'd4, 13'd4, 1'b1);
        queue_pixels(8, 20);
        write_reg(REG_UNUSED, DIM_W'($urandom));
        queue_pixels(8, 20);
        queue_drains(frame_lag());
        frames_run++;

        for (int unsigned mode = 0; mode < 4; mode++)
        begin
            set_idle(mode);
            while (random_beats < ITEM_GOAL * (mode + 1) / 4)
            begin
                if (must_write || $urandom_range(99) < 70)
                begin
                    set_shape(($urandom_range(9) == 0) ? DIM_W'($urandom_range(0, 24))
                                                       : DIM_W'($urandom_range(1, 10)),
                              ($urandom_range(9) == 0) ? DIM_W'(0)
                                                       : DIM_W'($urandom_range(1, 8)),
                              1'($urandom_range(1)));
                end
                must_write = 0;
                pixels = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
                lag = frame_lag();
                hole = hole_choices[$urandom_range(5)];
                split = $urandom_range(1, pixels);
                frames_run++;
                case ($urandom_range(9))
                    0:
                    begin
                        queue_pixels(split, hole);
                        wait_idle();
                        queue_pixels(pixels - split, hole);
                        queue_drains(lag);
                        random_beats += pixels + lag;
                    end
                    1:
                    begin
                        queue_pixels(split, hole);
                        must_write = 1;
                        random_beats += split;
                    end
                    default:
                    begin
                        queue_pixels(pixels, hole);
                        queue_drains(lag);
                        random_beats += pixels + lag;
                    end
                endcase
            end
        end

        set_idle(0);
        set_shape(13'd10, 13'd10, 1'b1);
        @(posedge clk);
        stall_asks++;
        queue_pixels(100, 15);
        queue_drains(frame_lag());
        frames_run++;

        set_shape(13'd8191, 13'd1, 1'b0);
        queue_pixels(MAX_WIDTH, 10);
        queue_drains(frame_lag());
        frames_run++;

        set_idle(3);
        set_shape(13'd1, 13'd4096, 1'b1);
        queue_pixels(MAX_HEIGHT, 10);
        queue_drains(frame_lag());
        frames_run++;

        wait_idle();
        repeat (20) @(negedge clk);

        $display("Ran %0d frames over %0d frame shapes, single and double ring, with idling,",
                 frames_run, shapes_used);
        $display("long output stalls and mid-frame pauses: %0d beats in, %0d decisions (%0d kept).",
                 beats_in, decisions, kept_total);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
